/* rtl/rsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rsf_pkg;

  // Sequencer states of the classification walk.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_SCAN,
    ST_SCORE,
    ST_HASH_SCAN,
    ST_HASH_DONE,
    ST_FINISH
  } state_t;

  // Item function codes.
  localparam logic FUNC_ADD      = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  // Configuration register indexes.
  localparam logic REG_THRESHOLD   = 1'b0;
  localparam logic REG_SMALL_LIMIT = 1'b1;

  // Field widths.
  localparam int ADDR_W   = 48;
  localparam int HASH_W   = 64;
  localparam int SCORE_W  = 4;
  localparam int THRESH_W = 4;
  localparam int LIMIT_W  = 21;
  localparam int CFG_W    = 21;

  // Register reset values.
  localparam logic [THRESH_W-1:0] THRESH_RESET = 4'd9;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 21'd4096;

  // Score weights.
  localparam logic [SCORE_W-1:0] PTS_PRIVATE   = 4'd2;
  localparam logic [SCORE_W-1:0] PTS_EXEC_WR   = 4'd3;
  localparam logic [SCORE_W-1:0] PTS_NO_MODULE = 4'd2;
  localparam logic [SCORE_W-1:0] PTS_SMALL     = 4'd1;
  localparam logic [SCORE_W-1:0] PTS_NO_PE     = 4'd1;
  localparam logic [SCORE_W-1:0] SCORE_MAX     = 4'd9;

endpackage

`default_nettype wire

/* rtl/rsf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/region_suspicion_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// An add transaction goes straight to ST_FINISH and then loads its result into the output register.
// A classify transaction walks the module table, scores the region and walks the hash store
// too when the region is suspicious: each table is walked one entry per cycle through its own
// registered read port, with one shared scan index and one compare unit.
// The next transaction is taken the cycle after the result loads; a stalled result delays it.
// Synchronous reset empties both tables and restores the register defaults; no clearing pass.

module region_suspicion_filter #(
  parameter int MODULE_SLOTS = 128,
  parameter int HASH_SLOTS   = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Configuration write port.
  input  wire logic                        cfg_en,
  input  wire logic                        cfg_index,
  input  wire logic [rsf_pkg::CFG_W-1:0]   cfg_data,
  // Input channel.
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        func,
  input  wire logic [rsf_pkg::ADDR_W-1:0]  base_address,
  input  wire logic [rsf_pkg::ADDR_W-1:0]  range_size,
  input  wire logic                        is_private,
  input  wire logic                        is_exec_writable,
  input  wire logic                        read_ok,
  input  wire logic                        has_pe_header,
  input  wire logic [rsf_pkg::HASH_W-1:0]  content_hash,
  // Output channel.
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [rsf_pkg::SCORE_W-1:0] score,
  output logic                             in_module,
  output logic                             suspicious,
  output logic                             dump,
  output logic                             stored
);

  import rsf_pkg::*;

  localparam int MAW = (MODULE_SLOTS > 1) ? $clog2(MODULE_SLOTS) : 1;
  localparam int HAW = (HASH_SLOTS > 1) ? $clog2(HASH_SLOTS) : 1;
  localparam int MCW = $clog2(MODULE_SLOTS + 1);
  localparam int HCW = $clog2(HASH_SLOTS + 1);
  localparam int SCW = (MCW > HCW) ? MCW : HCW;

  state_t state;
  state_t state_next;

  // Configuration registers.
  logic [THRESH_W-1:0] score_threshold;
  logic [LIMIT_W-1:0]  small_region_limit;

  // Table fill counts.
  logic [MCW-1:0] module_count;
  logic [HCW-1:0] hash_count;

  // Scan sequencer.
  logic [SCW-1:0] idx;
  logic           pend;
  logic           match;

  // Captured item fields.
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] size_r;
  logic              priv_r;
  logic              xw_r;
  logic              rok_r;
  logic              pe_r;
  logic [HASH_W-1:0] hash_r;

  // Result under construction.
  logic [SCORE_W-1:0] res_score;
  logic               res_inmod;
  logic               res_susp;
  logic               res_dump;
  logic               res_stored;

  // Memory ports.
  logic [2*ADDR_W-1:0] mod_rdata;
  logic [HASH_W-1:0]   hash_rdata;

  // Control and datapath wires.
  logic               accept;
  logic               scanning;
  logic [SCW-1:0]     scan_count;
  logic               issue;
  logic               mod_we;
  logic               hash_we;
  logic               out_free;
  logic               mod_hit;
  logic               hash_hit;
  logic [ADDR_W:0]    range_end;
  logic [SCORE_W-1:0] score_calc;
  logic               susp_calc;

  // Module range table, base in the upper half and size in the lower half.
  rsf_ram #(
    .WIDTH (2 * ADDR_W),
    .DEPTH (MODULE_SLOTS)
  ) u_mod_ram (
    .clk   (clk),
    .we    (mod_we),
    .waddr (module_count[MAW-1:0]),
    .wdata ({base_address, range_size}),
    .raddr (idx[MAW-1:0]),
    .rdata (mod_rdata)
  );

  // Seen-set of content hashes.
  rsf_ram #(
    .WIDTH (HASH_W),
    .DEPTH (HASH_SLOTS)
  ) u_hash_ram (
    .clk   (clk),
    .we    (hash_we),
    .waddr (hash_count[HAW-1:0]),
    .wdata (hash_r),
    .raddr (idx[HAW-1:0]),
    .rdata (hash_rdata)
  );

  // Compare unit: range check on the module entry, equality on the hash entry.
  always_comb begin
    range_end = {1'b0, mod_rdata[2*ADDR_W-1:ADDR_W]} + {1'b0, mod_rdata[ADDR_W-1:0]};
    mod_hit   = (base_r >= mod_rdata[2*ADDR_W-1:ADDR_W]) && ({1'b0, base_r} < range_end);
    hash_hit  = (hash_rdata == hash_r);
  end

  // Score of the captured region once the module walk is done.
  always_comb begin
    score_calc = (priv_r ? PTS_PRIVATE : '0)
               + (xw_r ? PTS_EXEC_WR : '0)
               + (match ? '0 : PTS_NO_MODULE)
               + ((size_r <= ADDR_W'(small_region_limit)) ? PTS_SMALL : '0)
               + ((rok_r && !pe_r) ? PTS_NO_PE : '0);
    susp_calc  = rok_r && (score_calc >= score_threshold);
  end

  // Sequencer outputs.
  always_comb begin
    in_stall   = (state != ST_IDLE);
    accept     = in_valid && !in_stall;
    scanning   = (state == ST_MOD_SCAN) || (state == ST_HASH_SCAN);
    scan_count = (state == ST_HASH_SCAN) ? SCW'(hash_count) : SCW'(module_count);
    issue      = scanning && (idx < scan_count);
    mod_we     = accept && (func == FUNC_ADD) && (module_count < MCW'(MODULE_SLOTS));
    hash_we    = (state == ST_HASH_DONE) && !match && (hash_count < HCW'(HASH_SLOTS));
    out_free   = !out_valid || !out_stall;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (func == FUNC_ADD) ? ST_FINISH : ST_MOD_SCAN;
        end
      end
      ST_MOD_SCAN: begin
        if (!issue && !pend) begin
          state_next = ST_SCORE;
        end
      end
      ST_SCORE: begin
        state_next = susp_calc ? ST_HASH_SCAN : ST_FINISH;
      end
      ST_HASH_SCAN: begin
        if (!issue && !pend) begin
          state_next = ST_HASH_DONE;
        end
      end
      ST_HASH_DONE: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state: sequencer, fill counts, output valid and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      module_count       <= '0;
      hash_count         <= '0;
      pend               <= 1'b0;
      out_valid          <= 1'b0;
      score_threshold    <= THRESH_RESET;
      small_region_limit <= LIMIT_RESET;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (mod_we) begin
        module_count <= module_count + MCW'(1);
      end
      if (hash_we) begin
        hash_count <= hash_count + HCW'(1);
      end
      if ((state == ST_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_en) begin
        case (cfg_index)
          REG_THRESHOLD:   score_threshold    <= cfg_data[THRESH_W-1:0];
          REG_SMALL_LIMIT: small_region_limit <= cfg_data[LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath: item capture, scan index, match flag and result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      base_r     <= base_address;
      size_r     <= range_size;
      priv_r     <= is_private;
      xw_r       <= is_exec_writable;
      rok_r      <= read_ok;
      pe_r       <= has_pe_header;
      hash_r     <= content_hash;
      idx        <= '0;
      match      <= 1'b0;
      res_score  <= '0;
      res_inmod  <= 1'b0;
      res_susp   <= 1'b0;
      res_dump   <= 1'b0;
      res_stored <= mod_we;
    end
    if (issue) begin
      idx <= idx + SCW'(1);
    end
    if ((state == ST_MOD_SCAN) && pend && mod_hit) begin
      match <= 1'b1;
    end
    if ((state == ST_HASH_SCAN) && pend && hash_hit) begin
      match <= 1'b1;
    end
    if (state == ST_SCORE) begin
      res_score <= score_calc;
      res_inmod <= match;
      res_susp  <= susp_calc;
      match     <= 1'b0;
      idx       <= '0;
    end
    if (state == ST_HASH_DONE) begin
      res_dump   <= !match;
      res_stored <= hash_we;
    end
  end

  // Output register, loaded when the previous result has left.
  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      score      <= res_score;
      in_module  <= res_inmod;
      suspicious <= res_susp;
      dump       <= res_dump;
      stored     <= res_stored;
    end
  end

endmodule

`default_nettype wire

/* rtl/rsf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module rsf_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [rsf_pkg::SCORE_W-1:0] score,
  input wire logic                        in_module,
  input wire logic                        suspicious,
  input wire logic                        dump,
  input wire logic                        stored
);

  import rsf_pkg::*;

  // A stalled result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(score) && $stable(in_module)
      && $stable(suspicious) && $stable(dump) && $stable(stored))
    else $error("stalled result changed");

  // An accepted transaction keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a transaction");

  // Score stays in range and a dump is always suspicious.
  a_score_dump: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (score <= SCORE_MAX) && (!dump || suspicious))
    else $error("score out of range or dump without suspicion");

  // A recorded hash is always a new one.
  a_stored_hash: assert property (@(posedge clk) disable iff (rst)
    out_valid && stored && suspicious |-> dump)
    else $error("hash recorded without dump");

  // A recorded module range carries a cleared classification.
  a_stored_add: assert property (@(posedge clk) disable iff (rst)
    out_valid && stored && !suspicious |-> (score == '0) && !in_module && !dump)
    else $error("add result with classification fields set");

endmodule

bind region_suspicion_filter rsf_checker u_rsf_checker (.*);

`default_nettype wire

/* tb/region_suspicion_filter_test.sv */
`timescale 1ns / 1ps

module region_suspicion_filter_test;
  import rsf_pkg::*;

  localparam int MOD_DEPTH      = 128;
  localparam int HASH_DEPTH     = 1024;
  localparam int HASH_POOL      = 24;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 70;
  localparam int HASH_BATCH     = 40;
  localparam int ADD_PERCENT    = 30;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int SETTLE_CYCLES  = 1300;
  localparam int IDLE_LIMIT     = 12000;
  localparam int REPORT_LIMIT   = 10;

  // Scoring weights and register defaults of the filter.
  localparam logic [SCORE_W-1:0]  PRIVATE_POINTS    = 4'd2;
  localparam logic [SCORE_W-1:0]  EXEC_WRITE_POINTS = 4'd3;
  localparam logic [SCORE_W-1:0]  UNMAPPED_POINTS   = 4'd2;
  localparam logic [SCORE_W-1:0]  SMALL_POINTS      = 4'd1;
  localparam logic [SCORE_W-1:0]  NO_HEADER_POINTS  = 4'd1;
  localparam logic [THRESH_W-1:0] DEFAULT_THRESHOLD = 4'd9;
  localparam logic [LIMIT_W-1:0]  DEFAULT_LIMIT     = 21'd4096;

  typedef enum logic {SEND_STEADY, SEND_BURSTY} send_pace_t;
  typedef enum logic [1:0] {TAKE_ALWAYS, TAKE_RANDOM, TAKE_PATTERN} take_pace_t;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    logic              priv;
    logic              exec_wr;
    logic              read_ok;
    logic              pe;
    logic [HASH_W-1:0] hash;
  } region_req_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               in_mod;
    logic               susp;
    logic               dump;
    logic               stored;
  } verdict_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_en = 1'b0;
  logic               cfg_index = REG_THRESHOLD;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  region_req_t        cur_req = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SCORE_W-1:0] score;
  logic               in_module;
  logic               suspicious;
  logic               dump;
  logic               stored;

  region_suspicion_filter dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_en           (cfg_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .func             (cur_req.func),
    .base_address     (cur_req.base),
    .range_size       (cur_req.size),
    .is_private       (cur_req.priv),
    .is_exec_writable (cur_req.exec_wr),
    .read_ok          (cur_req.read_ok),
    .has_pe_header    (cur_req.pe),
    .content_hash     (cur_req.hash),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .score            (score),
    .in_module        (in_module),
    .suspicious       (suspicious),
    .dump             (dump),
    .stored           (stored)
  );

  // Filter state as the scoreboard tracks it.
  logic [ADDR_W-1:0]   known_base [MOD_DEPTH];
  logic [ADDR_W-1:0]   known_size [MOD_DEPTH];
  int                  known_count = 0;
  logic [HASH_W-1:0]   seen_hash [HASH_DEPTH];
  int                  seen_count = 0;
  logic [THRESH_W-1:0] cur_threshold = DEFAULT_THRESHOLD;
  logic [LIMIT_W-1:0]  cur_small_limit = DEFAULT_LIMIT;

  // Stimulus bookkeeping.
  region_req_t       pending_regions [$];
  verdict_t          expected_verdicts [$];
  logic [ADDR_W-1:0] planned_mod_base [$];
  logic [ADDR_W-1:0] planned_mod_size [$];
  logic [HASH_W-1:0] hash_pool [HASH_POOL];

  send_pace_t send_pace = SEND_STEADY;
  take_pace_t take_pace = TAKE_RANDOM;
  logic       req_live = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  int         holdoff_tag = 0;
  int         holdoff_done = 0;
  int         hold_left = 0;
  int         stall_step = 0;
  int         quiet_cycles = 0;

  // Run statistics.
  int adds_taken = 0;
  int classifies_taken = 0;
  int verdicts_seen = 0;
  int mismatch_count = 0;
  int dump_count = 0;
  int duplicate_count = 0;
  int refused_hash_count = 0;
  int refused_add_count = 0;
  int config_writes = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Scores one transaction and updates the tracked tables.
  function automatic verdict_t classify_region(region_req_t r);
    verdict_t         v;
    logic [ADDR_W:0]  range_end;
    logic             seen;
    v = '0;
    seen = 1'b0;
    if (r.func == FUNC_ADD) begin
      if (known_count < MOD_DEPTH) begin
        known_base[known_count] = r.base;
        known_size[known_count] = r.size;
        known_count++;
        v.stored = 1'b1;
      end else begin
        refused_add_count++;
      end
    end else begin
      // A module covers its base up to, not including, base plus size.
      for (int i = 0; i < known_count; i++) begin
        range_end = {1'b0, known_base[i]} + {1'b0, known_size[i]};
        if (r.base >= known_base[i] && {1'b0, r.base} < range_end) v.in_mod = 1'b1;
      end
      if (r.priv) v.score += PRIVATE_POINTS;
      if (r.exec_wr) v.score += EXEC_WRITE_POINTS;
      if (!v.in_mod) v.score += UNMAPPED_POINTS;
      if (r.size <= ADDR_W'(cur_small_limit)) v.score += SMALL_POINTS;
      if (r.read_ok && !r.pe) v.score += NO_HEADER_POINTS;
      // Only suspicious regions touch the hash store.
      if (r.read_ok && v.score >= cur_threshold) begin
        v.susp = 1'b1;
        for (int i = 0; i < seen_count; i++) begin
          if (seen_hash[i] == r.hash) seen = 1'b1;
        end
        if (!seen) begin
          v.dump = 1'b1;
          if (seen_count < HASH_DEPTH) begin
            seen_hash[seen_count] = r.hash;
            seen_count++;
            v.stored = 1'b1;
          end
        end
      end
    end
    return v;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic region_req_t make_region(logic f, logic [ADDR_W-1:0] b,
                                              logic [ADDR_W-1:0] s, logic p, logic x,
                                              logic ok, logic e, logic [HASH_W-1:0] h);
    region_req_t r;
    r.func    = f;
    r.base    = b;
    r.size    = s;
    r.priv    = p;
    r.exec_wr = x;
    r.read_ok = ok;
    r.pe      = e;
    r.hash    = h;
    return r;
  endfunction

  // Random transaction: adds of varied ranges, classifies aimed at known
  // modules and their edges, sizes around the small-region limit, reused hashes.
  function automatic region_req_t random_region(int add_pct);
    region_req_t       r;
    int                pick;
    int                k;
    logic [ADDR_W-1:0] limit48;
    r = '0;
    limit48 = ADDR_W'(cur_small_limit);
    r.func    = ($urandom_range(99) < add_pct) ? FUNC_ADD : FUNC_CLASSIFY;
    r.priv    = 1'($urandom_range(1));
    r.exec_wr = 1'($urandom_range(1));
    r.read_ok = ($urandom_range(9) < 8);
    r.pe      = ($urandom_range(3) == 0);
    r.hash    = ($urandom_range(1) == 0) ? hash_pool[$urandom_range(HASH_POOL - 1)] : rand64();
    if (r.func == FUNC_ADD) begin
      pick = $urandom_range(9);
      r.base = (pick < 4) ? ADDR_W'(rand64()) : ADDR_W'({$urandom_range(4095), 16'h0});
      pick = $urandom_range(19);
      if (pick == 0) r.size = '0;
      else if (pick < 3) r.size = ADDR_W'(rand64());
      else r.size = ADDR_W'($urandom_range(1, 20'hFFFFF));
      planned_mod_base.push_back(r.base);
      planned_mod_size.push_back(r.size);
    end else begin
      pick = $urandom_range(9);
      if (planned_mod_base.size() != 0 && pick < 6) begin
        k = $urandom_range(planned_mod_base.size() - 1);
        if (pick < 4 && planned_mod_size[k] != 0)
          r.base = planned_mod_base[k] + ADDR_W'(rand64() % planned_mod_size[k]);
        else if (pick == 4) r.base = planned_mod_base[k] + planned_mod_size[k];
        else r.base = planned_mod_base[k] - 1'b1;
      end else if (pick == 6) begin
        r.base = ADDR_W'($urandom_range(65535));
      end else begin
        r.base = ADDR_W'(rand64());
      end
      case ($urandom_range(7))
        0: r.size = limit48;
        1: r.size = limit48 + 1'b1;
        2: r.size = limit48 - 1'b1;
        3: r.size = '0;
        4: r.size = ADDR_W'(rand64());
        default: r.size = ADDR_W'($urandom_range(21'h1FFFFF));
      endcase
    end
    return r;
  endfunction

  // Blocks until the sender has nothing left and every result has come back.
  task automatic wait_drained();
    while (pending_regions.size() != 0 || req_live || expected_verdicts.size() != 0)
      @(posedge clk);
  endtask

  // Writes both registers while the filter is idle. Upper data bits of the
  // threshold write carry noise that the register must drop.
  task automatic write_config(logic [THRESH_W-1:0] thr, logic [LIMIT_W-1:0] lim);
    logic [CFG_W-THRESH_W-1:0] noise;
    noise = (CFG_W-THRESH_W)'($urandom);
    @(posedge clk);
    cfg_en    <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= {noise, thr};
    @(posedge clk);
    cfg_index <= REG_SMALL_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    cfg_en <= 1'b0;
    cur_threshold   = thr;
    cur_small_limit = lim;
    config_writes  += 2;
  endtask

  // Sender: offers queued transactions back to back at steady pace, or in bursts with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      req_live = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (cur_req.func == FUNC_ADD) adds_taken++;
        else classifies_taken++;
        expected_verdicts.push_back(classify_region(cur_req));
        req_live = 1'b0;
      end
      if (!req_live) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_regions.size() != 0) begin
          cur_req  <= pending_regions.pop_front();
          in_valid <= 1'b1;
          req_live = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else if (send_pace == SEND_BURSTY) begin
            burst_left = $urandom_range(12);
            gap_left   = $urandom_range(1, 30);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls by the current pace, or holds off for a long stretch on request.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holdoff_tag != holdoff_done) begin
      holdoff_done = holdoff_tag;
      hold_left    = HOLDOFF_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (take_pace)
        TAKE_ALWAYS: out_stall <= 1'b0;
        TAKE_RANDOM: out_stall <= ($urandom_range(3) == 0);
        default: begin
          stall_step++;
          out_stall <= ((stall_step % 7) < 3);
        end
      endcase
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin : check_verdicts
    verdict_t got;
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {score, in_module, suspicious, dump, stored};
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: score=%0d in_module=%b suspicious=%b dump=%b stored=%b",
                   got.score, got.in_mod, got.susp, got.dump, got.stored);
      end else begin
        want = expected_verdicts.pop_front();
        if (want.dump && want.stored) dump_count++;
        if (want.dump && !want.stored) refused_hash_count++;
        if (want.susp && !want.dump) duplicate_count++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display({"mismatch on result %0d: expected score=%0d in_module=%b suspicious=%b ",
                      "dump=%b stored=%b, got score=%0d in_module=%b suspicious=%b dump=%b ",
                      "stored=%b"}, verdicts_seen, want.score, want.in_mod, want.susp,
                     want.dump, want.stored, got.score, got.in_mod, got.susp, got.dump,
                     got.stored);
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || cfg_en || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [THRESH_W-1:0] phase_thr [RANDOM_PHASES];
    logic [LIMIT_W-1:0]  phase_lim [RANDOM_PHASES];
    region_req_t         r;
    int                  add_n;
    int                  failures;
    phase_thr = '{4'd0, 4'd15, 4'd5, 4'd7, 4'd10, 4'd9};
    phase_lim = '{21'd0, 21'h1FFFFF, 21'd1048576, 21'd300, 21'd4096, 21'd65535};
    phase_lim[3] = LIMIT_W'($urandom_range(1, 1048576));
    hash_pool[0] = '0;
    hash_pool[1] = '1;
    for (int i = 2; i < HASH_POOL; i++) hash_pool[i] = rand64();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings: threshold 9, limit 4096.
    // First regions with an empty module table, then hash reuse and extreme hashes.
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h1000, 48'h1000, 1'b1, 1'b1, 1'b1,
                                          1'b0, 64'h0123_4567_89AB_CDEF));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h1000, 48'h1000, 1'b1, 1'b1, 1'b1,
                                          1'b0, 64'h0123_4567_89AB_CDEF));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, '0, '0, 1'b1, 1'b1, 1'b1, 1'b0, '0));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h2000, 48'h10, 1'b1, 1'b1, 1'b1,
                                          1'b0, '0));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, '1, 48'h1, 1'b1, 1'b1, 1'b1, 1'b0,
                                          '1));
    // Module ranges: an ordinary one, one reaching past the top of the address
    // space, and an empty one.
    pending_regions.push_back(make_region(FUNC_ADD, 48'h40_0000, 48'h1_0000, 1'b0, 1'b0, 1'b0,
                                          1'b0, '0));
    pending_regions.push_back(make_region(FUNC_ADD, 48'hFFFF_FFFF_F000, 48'h2000, 1'b0, 1'b0,
                                          1'b0, 1'b0, '0));
    pending_regions.push_back(make_region(FUNC_ADD, 48'h80_0000, '0, 1'b0, 1'b0, 1'b0, 1'b0,
                                          '0));
    // Bases on and around the range edges.
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h40_0000, 48'h2000, 1'b1, 1'b1,
                                          1'b1, 1'b0, 64'hA1));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h40_FFFF, 48'h2000, 1'b1, 1'b1,
                                          1'b1, 1'b0, 64'hA2));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h41_0000, 48'h1000, 1'b1, 1'b1,
                                          1'b1, 1'b0, 64'hA3));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h3F_FFFF, 48'h1000, 1'b1, 1'b1,
                                          1'b1, 1'b0, 64'hA4));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, '1, 48'h1000, 1'b1, 1'b1, 1'b1, 1'b0,
                                          64'hA5));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h80_0000, 48'h1000, 1'b1, 1'b1,
                                          1'b1, 1'b0, 64'hA6));
    // Size just over the limit and at full width, a failed read, a PE header.
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h9000, 48'h1001, 1'b1, 1'b1, 1'b1,
                                          1'b0, 64'hA7));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h9000, '1, 1'b1, 1'b1, 1'b1, 1'b0,
                                          64'hA8));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h9000, 48'h10, 1'b1, 1'b1, 1'b0,
                                          1'b0, 64'hA9));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h9000, 48'h10, 1'b1, 1'b1, 1'b1,
                                          1'b1, 64'hAA));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'h100, 48'h10_0000, 1'b0, 1'b0,
                                          1'b1, 1'b0, 64'hAB));
    // A range covering almost everything; other fields of an add are ignored.
    pending_regions.push_back(make_region(FUNC_ADD, '0, '1, 1'b1, 1'b1, 1'b1, 1'b1, '1));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, '0, 48'h10, 1'b1, 1'b1, 1'b1, 1'b0,
                                          64'hAC));
    pending_regions.push_back(make_region(FUNC_CLASSIFY, 48'hFFFF_FFFF_FFFE, 48'h10, 1'b1,
                                          1'b1, 1'b1, 1'b0, 64'hAD));
    wait_drained();

    // Random phases, each at its own register setting and pacing.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_config(phase_thr[p], phase_lim[p]);
      send_pace = (p % 2 == 0) ? SEND_BURSTY : SEND_STEADY;
      case (p % 3)
        0: take_pace = TAKE_RANDOM;
        1: take_pace = TAKE_ALWAYS;
        default: take_pace = TAKE_PATTERN;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) pending_regions.push_back(random_region(ADD_PERCENT));
      // Long receiver hold-off while the sender keeps offering.
      if (p == 1) holdoff_tag++;
      wait_drained();
    end

    // Fill the module table to capacity and keep going past it, then a batch of
    // readable regions that are all suspicious at threshold 0.
    write_config(4'd0, DEFAULT_LIMIT);
    send_pace = SEND_STEADY;
    take_pace = TAKE_ALWAYS;
    add_n = (known_count < MOD_DEPTH) ? MOD_DEPTH - known_count + 4 : 4;
    for (int i = 0; i < add_n; i++) pending_regions.push_back(random_region(100));
    for (int i = 0; i < HASH_BATCH; i++) begin
      r = random_region(0);
      r.read_ok = 1'b1;
      r.hash = (i % 8 == 0) ? hash_pool[$urandom_range(HASH_POOL - 1)] : rand64();
      pending_regions.push_back(r);
    end
    wait_drained();

    // A last mix with the module table full.
    write_config(4'd3, 21'd8192);
    send_pace = SEND_BURSTY;
    take_pace = TAKE_RANDOM;
    for (int i = 0; i < 20; i++) pending_regions.push_back(random_region(ADD_PERCENT));
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    failures = mismatch_count + expected_verdicts.size();
    $display("covered %0d module adds (%0d ignored by a full table) and %0d classifies %s %0d",
             adds_taken, refused_add_count, classifies_taken, "across register writes:",
             config_writes);
    $display("classifies gave %0d new dumps, %0d duplicates and %0d dumps refused by a full store",
             dump_count, duplicate_count, refused_hash_count);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures, %0d results still expected", failures, expected_verdicts.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
